// ===== design/tgm_pkg.sv =====
package tgm_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_GAIN,
        ST_RAMP,
        ST_ROUND
    } tgm_state_t;

    // Fade direction
    typedef enum logic [1:0] {
        RAMP_HOLD,
        RAMP_UP,
        RAMP_DOWN
    } ramp_dir_t;

    // Wave modes
    localparam logic [1:0] MODE_SINE     = 2'd0;
    localparam logic [1:0] MODE_INTERMOD = 2'd1;
    localparam logic [1:0] MODE_LOW      = 2'd2;

    // Register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_WAVE_MODE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SINE_STEP  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HERTZ_STEP = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_LOG2 = 3'd4;

    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned STEP_W      = 32;
    localparam int unsigned HERTZ_W     = 20;
    localparam int unsigned GAIN_W      = 16;
    localparam int unsigned LOG2_W      = 4;
    localparam int unsigned MULT_W      = 11;
    localparam int unsigned RAMP_W      = 17;
    localparam int unsigned TONE_IDX_W  = 2;
    localparam int unsigned TONES       = 4;

    localparam logic [RAMP_W-1:0] UNITY = 17'd65536;

    // Right shift of |value*gain*ramp|: Q15 gain, Q16 ramp, plus 1/4 for four tones
    localparam int unsigned SHIFT_ONE  = 31;
    localparam int unsigned SHIFT_FOUR = 33;

    // Reset values of the registers
    localparam logic [STEP_W-1:0]  SINE_STEP_RST  = 32'd39409;
    localparam logic [HERTZ_W-1:0] HERTZ_STEP_RST = 20'd89478;
    localparam logic [GAIN_W-1:0]  GAIN_RST       = 16'd32768;
    localparam logic [LOG2_W-1:0]  BLOCK_LOG2_RST = 4'd14;

    // Tone frequency in Hz for each four-tone set
    function automatic logic [MULT_W-1:0] tone_mult(
        input logic                  low_set,
        input logic [TONE_IDX_W-1:0] idx
    );
        logic [MULT_W-1:0] m;
        begin
            m = '0;
            if (low_set)
            begin
                case (idx)
                    2'd0:    m = 11'd220;
                    2'd1:    m = 11'd262;
                    2'd2:    m = 11'd294;
                    default: m = 11'd392;
                endcase
            end
            else
            begin
                case (idx)
                    2'd0:    m = 11'd857;
                    2'd1:    m = 11'd863;
                    2'd2:    m = 11'd1372;
                    default: m = 11'd1388;
                endcase
            end
            return m;
        end
    endfunction

    // One table entry, evaluated at elaboration only.
    // Quarter wave from a degree 9 Q30 polynomial, clamped to 1.0.
    function automatic logic signed [31:0] sine_entry(
        input int unsigned k,
        input int unsigned table_bits,
        input int unsigned sample_bits
    );
        logic [63:0] quarter;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] p;
        logic [63:0] fs;
        logic [63:0] mag;
        logic [63:0] one;
        begin
            one     = 64'd1 << 30;
            quarter = 64'd1 << (table_bits - 2);
            q       = 64'(k) >> (table_bits - 2);
            r       = 64'(k) & (quarter - 64'd1);
            if (q[0])
            begin
                r = quarter - r;
            end
            z  = r << (30 - (table_bits - 2));
            z2 = (z * z) >> 30;
            p  = 64'd5026996 - ((z2 * 64'd172272) >> 30);
            p  = 64'd85569306 - ((z2 * p) >> 30);
            p  = 64'd693598668 - ((z2 * p) >> 30);
            p  = 64'd1686629713 - ((z2 * p) >> 30);
            p  = (z * p) >> 30;
            if (p > one)
            begin
                p = one;
            end
            fs  = (64'd1 << (sample_bits - 1)) - 64'd1;
            mag = (p * fs + (one >> 1)) >> 30;
            return q[1] ? -$signed(mag[31:0]) : $signed(mag[31:0]);
        end
    endfunction

endpackage

// ===== design/tone_generator_with_mute_ramp.sv =====
// Test tone generator: each accepted request (block_start, mute) yields one signed
// sample. Mode 0 plays one sine stepped by sine_step; modes 1 and 2 average four sines
// at fixed multiples of hertz_step (857/863/1372/1388 Hz or 220/262/294/392 Hz). The
// sample is scaled by gain (Q1.15) and by a mute fade (Q16) that starts at a block
// start when mute changes and runs linearly over 2^block_length_log2 samples, then
// rounded half away from zero and clamped to +-(2^(SAMPLE_BITS-1)-1). One request is
// in flight at a time. In the four-tone modes the four phase reads go one per cycle
// through the phase memory and the shared sine table; the table output then passes
// two multiply stages and the rounding stage. A finished sample waits in the output
// register while the next request is already being worked on. Registers are to be
// written only while idle; the block itself does not enforce this, and the write
// port is always ready. After reset the phases are zero, the fade level is
// zero and the last mute is taken as set, so output is silent until an unmuted
// block start.
module tone_generator_with_mute_ramp #(
    parameter int unsigned PHASE_BITS  = 32,
    parameter int unsigned TABLE_BITS  = 10,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                block_start,
    input  logic                                mute,
    // sample channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_BITS-1:0]       sample,
    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tgm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tgm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int unsigned ACC_W = SAMPLE_BITS + 2;             // sum of four samples
    localparam int unsigned MAG_W = SAMPLE_BITS + 1;
    localparam int unsigned P1_W  = MAG_W + tgm_pkg::GAIN_W;
    localparam int unsigned P2_W  = P1_W + tgm_pkg::RAMP_W;
    localparam int unsigned SUM_W = P2_W + 1;
    localparam logic [SAMPLE_BITS-1:0] FS_PEAK = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SUM_W-1:0] HALF_ONE  = SUM_W'(1) << (tgm_pkg::SHIFT_ONE - 1);
    localparam logic [SUM_W-1:0] HALF_FOUR = SUM_W'(1) << (tgm_pkg::SHIFT_FOUR - 1);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [1:0]                       wave_mode_reg;
    logic [tgm_pkg::STEP_W-1:0]       sine_step_reg;
    logic [tgm_pkg::HERTZ_W-1:0]      hertz_step_reg;
    logic [tgm_pkg::GAIN_W-1:0]       gain_reg;
    logic [tgm_pkg::LOG2_W-1:0]       block_log2_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_mode_reg  <= tgm_pkg::MODE_SINE;
            sine_step_reg  <= tgm_pkg::SINE_STEP_RST;
            hertz_step_reg <= tgm_pkg::HERTZ_STEP_RST;
            gain_reg       <= tgm_pkg::GAIN_RST;
            block_log2_reg <= tgm_pkg::BLOCK_LOG2_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tgm_pkg::REG_WAVE_MODE:  wave_mode_reg  <= cfg_data[1:0];
                tgm_pkg::REG_SINE_STEP:  sine_step_reg  <= cfg_data[tgm_pkg::STEP_W-1:0];
                tgm_pkg::REG_HERTZ_STEP: hertz_step_reg <= cfg_data[tgm_pkg::HERTZ_W-1:0];
                tgm_pkg::REG_GAIN:       gain_reg       <= cfg_data[tgm_pkg::GAIN_W-1:0];
                tgm_pkg::REG_BLOCK_LOG2: block_log2_reg <= cfg_data[tgm_pkg::LOG2_W-1:0];
                default: ;  // writes past the list are dropped
            endcase
        end
    end

    // Mode 3 plays as single sine
    logic four_tone;
    logic low_set;

    always_comb
    begin
        case (wave_mode_reg) inside
            tgm_pkg::MODE_INTERMOD, tgm_pkg::MODE_LOW: four_tone = 1'b1;
            tgm_pkg::MODE_SINE:                        four_tone = 1'b0;
            default:                                   four_tone = 1'b0;
        endcase
    end

    assign low_set = (wave_mode_reg == tgm_pkg::MODE_LOW);

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    tgm_pkg::tgm_state_t state_reg;
    tgm_pkg::tgm_state_t state_next;

    logic [tgm_pkg::TONE_IDX_W-1:0] tone_idx_reg;
    logic [tgm_pkg::TONE_IDX_W-1:0] tone_idx_next;
    logic [tgm_pkg::TONE_IDX_W-1:0] last_idx;

    logic rom_vld_reg;
    logic rom_last_reg;
    logic out_valid_reg;

    logic accept;
    logic read_issue;
    logic gain_en;
    logic ramp_en;
    logic round_en;

    assign last_idx = four_tone ? tgm_pkg::TONE_IDX_W'(tgm_pkg::TONES - 1) : '0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tgm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tgm_pkg::ST_READ;
                end
            end
            tgm_pkg::ST_READ:
            begin
                if (tone_idx_reg == last_idx)
                begin
                    state_next = tgm_pkg::ST_DRAIN;
                end
            end
            tgm_pkg::ST_DRAIN:
            begin
                if (rom_vld_reg && rom_last_reg)
                begin
                    state_next = tgm_pkg::ST_GAIN;
                end
            end
            tgm_pkg::ST_GAIN:  state_next = tgm_pkg::ST_RAMP;
            tgm_pkg::ST_RAMP:  state_next = tgm_pkg::ST_ROUND;
            tgm_pkg::ST_ROUND:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = tgm_pkg::ST_IDLE;
                end
            end
            default: state_next = tgm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        accept     = 1'b0;
        read_issue = 1'b0;
        gain_en    = 1'b0;
        ramp_en    = 1'b0;
        round_en   = 1'b0;
        unique case (state_reg)
            tgm_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                accept   = in_valid;
            end
            tgm_pkg::ST_READ:  read_issue = 1'b1;
            tgm_pkg::ST_DRAIN: ;
            tgm_pkg::ST_GAIN:  gain_en = 1'b1;
            tgm_pkg::ST_RAMP:  ramp_en = 1'b1;
            tgm_pkg::ST_ROUND: round_en = !out_valid_reg || !out_stall;
            default: ;
        endcase
    end

    assign tone_idx_next = accept     ? '0 :
                           read_issue ? tone_idx_reg + 1'b1 : tone_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tgm_pkg::ST_IDLE;
            tone_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            tone_idx_reg <= tone_idx_next;
        end
    end

    // ---------------------------------------------------------------------
    // Mute fade: block start sets level and direction, the level then moves
    // by 2^(16-log2) once per sample. ramp_use_reg is the level for this sample.
    // ---------------------------------------------------------------------
    logic [tgm_pkg::RAMP_W-1:0] ramp_level_reg;
    logic [tgm_pkg::RAMP_W-1:0] ramp_level_next;
    logic [tgm_pkg::RAMP_W-1:0] ramp_start;
    logic [tgm_pkg::RAMP_W-1:0] ramp_use_reg;
    logic [tgm_pkg::RAMP_W-1:0] ramp_step;
    logic [tgm_pkg::RAMP_W:0]   ramp_sum;
    tgm_pkg::ramp_dir_t         ramp_dir_reg;
    tgm_pkg::ramp_dir_t         ramp_dir_start;
    logic                       mute_prev_reg;
    logic                       mute_prev_next;

    always_comb
    begin
        ramp_start     = ramp_level_reg;
        ramp_dir_start = ramp_dir_reg;
        mute_prev_next = mute_prev_reg;
        if (block_start)
        begin
            mute_prev_next = mute;
            if (mute_prev_reg)
            begin
                ramp_start     = '0;
                ramp_dir_start = mute ? tgm_pkg::RAMP_HOLD : tgm_pkg::RAMP_UP;
            end
            else
            begin
                ramp_start     = tgm_pkg::UNITY;
                ramp_dir_start = mute ? tgm_pkg::RAMP_DOWN : tgm_pkg::RAMP_HOLD;
            end
        end
    end

    assign ramp_step = tgm_pkg::RAMP_W'(1) << (5'd16 - {1'b0, block_log2_reg});
    assign ramp_sum  = {1'b0, ramp_start} + {1'b0, ramp_step};

    always_comb
    begin
        case (ramp_dir_start)
            tgm_pkg::RAMP_UP:
                ramp_level_next = (ramp_sum > {1'b0, tgm_pkg::UNITY}) ?
                                  tgm_pkg::UNITY : ramp_sum[tgm_pkg::RAMP_W-1:0];
            tgm_pkg::RAMP_DOWN:
                ramp_level_next = (ramp_start <= ramp_step) ? '0 : ramp_start - ramp_step;
            default:
                ramp_level_next = ramp_start;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_level_reg <= '0;
            ramp_dir_reg   <= tgm_pkg::RAMP_HOLD;
            mute_prev_reg  <= 1'b1;
        end
        else if (accept)
        begin
            ramp_level_reg <= ramp_level_next;
            ramp_dir_reg   <= ramp_dir_start;
            mute_prev_reg  <= mute_prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ramp_use_reg <= ramp_start;
        end
    end

    // ---------------------------------------------------------------------
    // Phase memory: read in READ, write back in the next cycle. Each sample
    // touches each entry that it uses once and the next request starts only after the
    // last write-back, so reads never see a pending write.
    // Per-entry valid bits give the zero reset value.
    // ---------------------------------------------------------------------
    logic [PHASE_BITS-1:0]           phase_mem [tgm_pkg::TONES];
    logic [tgm_pkg::TONES-1:0]       phase_ok_reg;
    logic [PHASE_BITS-1:0]           phase_rd_reg;
    logic                            ph_hit_reg;
    logic                            ph_vld_reg;
    logic                            ph_last_reg;
    logic [tgm_pkg::TONE_IDX_W-1:0]  ph_addr_reg;
    logic [tgm_pkg::STEP_W-1:0]      inc_reg;
    logic [tgm_pkg::STEP_W-1:0]      inc_next;
    logic [PHASE_BITS-1:0]           phase_q;
    logic [PHASE_BITS-1:0]           phase_wr_data;

    // 11 x 20 bit constant-coefficient product, registered before the add
    assign inc_next = four_tone ?
        tgm_pkg::STEP_W'(tgm_pkg::tone_mult(low_set, tone_idx_reg) * hertz_step_reg) :
        sine_step_reg;

    assign phase_q       = ph_hit_reg ? phase_rd_reg : '0;
    assign phase_wr_data = phase_q + PHASE_BITS'(inc_reg);

    always_ff @(posedge clk)
    begin
        if (read_issue)
        begin
            phase_rd_reg <= phase_mem[tone_idx_reg];
            inc_reg      <= inc_next;
            ph_addr_reg  <= tone_idx_reg;
            ph_last_reg  <= (tone_idx_reg == last_idx);
            ph_hit_reg   <= phase_ok_reg[tone_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ph_vld_reg)
        begin
            phase_mem[ph_addr_reg] <= phase_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ok_reg <= '0;
            ph_vld_reg   <= 1'b0;
            rom_vld_reg  <= 1'b0;
            rom_last_reg <= 1'b0;
        end
        else
        begin
            if (ph_vld_reg)
            begin
                phase_ok_reg[ph_addr_reg] <= 1'b1;
            end
            ph_vld_reg   <= read_issue;
            rom_vld_reg  <= ph_vld_reg;
            rom_last_reg <= ph_vld_reg && ph_last_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Sine table lookup and accumulation
    // ---------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] rom_data;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [ACC_W-1:0]       acc_next;

    tgm_sine_rom #(
        .TABLE_BITS  (TABLE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sine_rom (
        .clk     (clk),
        .rd_en   (ph_vld_reg),
        .rd_addr (phase_q[PHASE_BITS-1 -: TABLE_BITS]),
        .rd_data (rom_data)
    );

    always_comb
    begin
        acc_next = acc_reg;
        if (accept)
        begin
            acc_next = '0;
        end
        else if (rom_vld_reg)
        begin
            acc_next = acc_reg + ACC_W'(rom_data);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // ---------------------------------------------------------------------
    // Scaling: |acc| * gain, then * ramp, then round half away and clamp
    // ---------------------------------------------------------------------
    logic [ACC_W-1:0]       acc_abs;
    logic [P1_W-1:0]        prod1_reg;
    logic [P1_W-1:0]        prod1_next;
    logic [P2_W-1:0]        prod2_reg;
    logic [P2_W-1:0]        prod2_next;
    logic                   neg_reg;
    logic [SUM_W-1:0]       round_sum;
    logic [SUM_W-1:0]       round_shr;
    logic [SAMPLE_BITS-1:0] mag_clamped;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] sample_next;

    assign acc_abs    = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign prod1_next = acc_abs[MAG_W-1:0] * gain_reg;
    assign prod2_next = prod1_reg * ramp_use_reg;

    assign round_sum   = SUM_W'(prod2_reg) + (four_tone ? HALF_FOUR : HALF_ONE);
    assign round_shr   = four_tone ? (round_sum >> tgm_pkg::SHIFT_FOUR) :
                                     (round_sum >> tgm_pkg::SHIFT_ONE);
    assign mag_clamped = (round_shr > SUM_W'(FS_PEAK)) ? FS_PEAK :
                                                         round_shr[SAMPLE_BITS-1:0];
    assign sample_next = neg_reg ? (~mag_clamped + 1'b1) : mag_clamped;

    always_ff @(posedge clk)
    begin
        if (gain_en)
        begin
            prod1_reg <= prod1_next;
            neg_reg   <= acc_reg[ACC_W-1];
        end
        if (ramp_en)
        begin
            prod2_reg <= prod2_next;
        end
        if (round_en)
        begin
            sample_reg <= sample_next;
        end
    end

    // Output register: holds until taken, reloaded only when free or taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (round_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = $signed(sample_reg);

`ifndef SYNTHESIS
    // Write-back and a new read never hit the same phase entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (ph_vld_reg && read_issue) |-> (ph_addr_reg != tone_idx_reg))
        else $error("phase memory read and write-back collide");

    // Fade level stays within unity
    assert property (@(posedge clk) disable iff (!rst_n)
        ramp_level_reg <= tgm_pkg::UNITY)
        else $error("fade level above unity");

    // Every table read returns data to the accumulator in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        ph_vld_reg |=> rom_vld_reg)
        else $error("table read lost");

    // A new sample appears only out of the rounding stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == tgm_pkg::ST_ROUND))
        else $error("output valid without a finished sample");

    // No request is taken while the sequencer is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != tgm_pkg::ST_IDLE) |-> !accept)
        else $error("request accepted while busy");
`endif

endmodule

// ===== design/tgm_sine_rom.sv =====
// Full-wave sine table, registered read
module tgm_sine_rom #(
    parameter int unsigned TABLE_BITS  = 10,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [TABLE_BITS-1:0]         rd_addr,
    output logic signed [SAMPLE_BITS-1:0] rd_data
);

    localparam int unsigned DEPTH = 2 ** TABLE_BITS;

    logic signed [SAMPLE_BITS-1:0] rom [DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_rom
        assign rom[k] = SAMPLE_BITS'(tgm_pkg::sine_entry(k, TABLE_BITS, SAMPLE_BITS));
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= rom[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== test/tb_tone_generator_with_mute_ramp.sv =====
`timescale 1ns / 1ps

// Bench for the tone generator.
// Requests (block_start, mute) go in and each one yields a single signed sample.
// A predictor in this module tracks phases, the fade and the register shadows.
// Every accepted request pushes one predicted sample; the output monitor pops and compares.
module tb_tone_generator_with_mute_ramp;

    import tgm_pkg::*;

    // Wave mode code the RTL does not name; it must play a single sine
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned ROM_SIZE   = 1024;
    localparam int unsigned FS_PEAK    = 32767;
    localparam longint      Q30_ONE    = 64'd1 << 30;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // request channel
    logic in_valid = 1'b0;
    logic in_stall;
    logic block_start = 1'b0;
    logic mute = 1'b0;

    // sample channel
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] sample;

    // register write channel
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_WAVE_MODE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Register shadows, starting at the reset values
    logic [1:0] cfg_mode = MODE_SINE;
    logic [STEP_W-1:0] cfg_sine_step = SINE_STEP_RST;
    logic [HERTZ_W-1:0] cfg_hertz = HERTZ_STEP_RST;
    logic [GAIN_W-1:0] cfg_gain = GAIN_RST;
    logic [LOG2_W-1:0] cfg_log2 = BLOCK_LOG2_RST;

    // Predictor state: four phase accumulators, the fade and the last sampled mute
    logic [31:0] phase_acc [TONES];
    logic [RAMP_W-1:0] fade_level = '0;
    ramp_dir_t fade_dir = RAMP_HOLD;
    logic mute_last = 1'b1;
    int sine_rom [ROM_SIZE];

    // Predicted samples, oldest first
    logic signed [15:0] pending_samples [$];

    // Traffic shaping: percent of cycles each side idles, plus a counted output hold-off
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;

    int mismatch_count = 0;
    int samples_checked = 0;

    tone_generator_with_mute_ramp DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .block_start (block_start),
        .mute        (mute),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample      (sample),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // One entry of the full-wave sine ROM. The first quarter comes from the degree 9
    // Q30 polynomial, clamped to 1.0; the other quarters mirror it.
    function automatic int rom_entry(input int unsigned k);
        int unsigned quad;
        int unsigned rem;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] p;
        logic [63:0] mag;
        quad = k >> 8;
        rem  = k & 32'd255;
        if (quad[0])
        begin
            rem = 256 - rem;
        end
        z  = 64'(rem) << 22;
        z2 = (z * z) >> 30;
        p  = 64'd5026996 - ((z2 * 64'd172272) >> 30);
        p  = 64'd85569306 - ((z2 * p) >> 30);
        p  = 64'd693598668 - ((z2 * p) >> 30);
        p  = 64'd1686629713 - ((z2 * p) >> 30);
        p  = (z * p) >> 30;
        if (p > Q30_ONE)
        begin
            p = Q30_ONE;
        end
        mag = (p * 64'(FS_PEAK) + (Q30_ONE >> 1)) >> 30;
        return quad[1] ? -int'(mag) : int'(mag);
    endfunction

    // Tone multiple in Hz for each four-tone set
    function automatic int unsigned tone_hz(input logic low_set, input int idx);
        int unsigned hz;
        case (idx)
            0:       hz = low_set ? 220 : 857;
            1:       hz = low_set ? 262 : 863;
            2:       hz = low_set ? 294 : 1372;
            default: hz = low_set ? 392 : 1388;
        endcase
        return hz;
    endfunction

    // Predict the sample for one request and advance phases and fade.
    function automatic logic signed [15:0] synth_sample(input logic bs, input logic m);
        longint acc;
        logic neg;
        logic [63:0] mag;
        logic [63:0] rounded;
        logic [63:0] inc;
        int unsigned shift;
        int unsigned ramp_step;
        int unsigned lvl;
        // block start: the (previous, new) mute pair restarts the fade
        if (bs)
        begin
            if (mute_last)
            begin
                fade_level = '0;
                fade_dir   = m ? RAMP_HOLD : RAMP_UP;
            end
            else
            begin
                fade_level = UNITY;
                fade_dir   = m ? RAMP_DOWN : RAMP_HOLD;
            end
            mute_last = m;
        end
        // oscillators; the unused mode falls through to the single sine
        if (cfg_mode == MODE_INTERMOD || cfg_mode == MODE_LOW)
        begin
            acc = 0;
            for (int i = 0; i < TONES; i++)
            begin
                acc += sine_rom[phase_acc[i][31:22]];
                inc = 64'(tone_hz(cfg_mode == MODE_LOW, i)) * 64'(cfg_hertz);
                phase_acc[i] = phase_acc[i] + inc[31:0];
            end
            shift = SHIFT_FOUR;
        end
        else
        begin
            acc = sine_rom[phase_acc[0][31:22]];
            phase_acc[0] = phase_acc[0] + cfg_sine_step;
            shift = SHIFT_ONE;
        end
        // scale by gain and fade, round half away from zero, clamp to full scale
        neg = (acc < 0);
        mag = neg ? 64'(-acc) : 64'(acc);
        mag = mag * 64'(cfg_gain) * 64'(fade_level);
        rounded = (mag + (64'd1 << (shift - 1))) >> shift;
        if (rounded > 64'(FS_PEAK))
        begin
            rounded = 64'(FS_PEAK);
        end
        // fade moves after the sample is formed
        ramp_step = 32'd1 << (16 - cfg_log2);
        if (fade_dir == RAMP_UP)
        begin
            lvl = fade_level + ramp_step;
            fade_level = (lvl > UNITY) ? UNITY : lvl[RAMP_W-1:0];
        end
        else if (fade_dir == RAMP_DOWN)
        begin
            fade_level = (fade_level <= ramp_step) ? '0 : RAMP_W'(fade_level - ramp_step);
        end
        return neg ? -$signed(rounded[15:0]) : $signed(rounded[15:0]);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 40)
        begin
            $display("MISMATCH at %0t, sample %0d: %s, got %0d, expected %0d",
                     $time, samples_checked, what, got, want);
        end
    endtask

    // Send one request. The sender may idle first; valid stays up through a stall.
    // The prediction is made at the edge that accepts the request.
    task automatic push_request(input logic bs, input logic m);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        block_start <= bs;
        mute        <= m;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pending_samples.push_back(synth_sample(bs, m));
    endtask

    // Drop valid and wait until every predicted sample has come out
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_WAVE_MODE:  cfg_mode = data[1:0];
            REG_SINE_STEP:  cfg_sine_step = data;
            REG_HERTZ_STEP: cfg_hertz = data[HERTZ_W-1:0];
            REG_GAIN:       cfg_gain = data[GAIN_W-1:0];
            REG_BLOCK_LOG2: cfg_log2 = data[LOG2_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Registers change only with the block drained
    task automatic load_settings(input logic [1:0] mode, input logic [31:0] sstep,
                                 input logic [19:0] hstep, input logic [15:0] gain,
                                 input logic [3:0] log2);
        settle();
        write_reg(REG_WAVE_MODE, 32'(mode));
        write_reg(REG_SINE_STEP, sstep);
        write_reg(REG_HERTZ_STEP, 32'(hstep));
        write_reg(REG_GAIN, 32'(gain));
        write_reg(REG_BLOCK_LOG2, 32'(log2));
    endtask

    task automatic random_settings();
        logic [31:0] sstep;
        logic [15:0] gain;
        logic [3:0] log2;
        case ($urandom_range(3))
            0:       sstep = $urandom();
            1:       sstep = $urandom_range(0, 32'h00FF_FFFF);
            2:       sstep = 32'hFFFF_FFFF - $urandom_range(0, 32'h000F_FFFF);
            default: sstep = $urandom_range(1) ? 32'h8000_0000 : 32'h0000_0000;
        endcase
        case ($urandom_range(5))
            0:       gain = 16'd0;
            1:       gain = 16'd32768;
            2:       gain = 16'hFFFF;
            default: gain = 16'($urandom());
        endcase
        // mostly short fades so that they finish inside the random blocks
        log2 = ($urandom_range(9) < 7) ? 4'($urandom_range(0, 5)) : 4'($urandom_range(6, 15));
        load_settings(2'($urandom_range(3)), sstep, 20'($urandom_range(0, 20'hFFFFF)),
                      gain, log2);
    endtask

    // Mostly well-formed blocks (start with a block-start request, then plain ticks), lengths
    // around the fade length so fades finish early, late or get cut off; some noise.
    task automatic random_traffic(input int n_items);
        int sent;
        int run;
        int span;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) < 8)
            begin
                span = 2 << cfg_log2;
                run  = $urandom_range(1, (span > 40) ? 40 : span + 1);
                push_request(1'b1, 1'($urandom_range(1)));
                repeat (run - 1)
                begin
                    push_request(1'b0, 1'($urandom_range(1)));
                end
                sent += run;
            end
            else
            begin
                repeat (3)
                begin
                    push_request(1'($urandom_range(1)), 1'($urandom_range(1)));
                end
                sent += 3;
            end
        end
    endtask

    // Reset values: silent until an unmuted block start, then a slow fade in
    task automatic test_after_reset();
        push_request(1'b0, 1'b0);
        push_request(1'b0, 1'b1);
        push_request(1'b1, 1'b0);
        push_request(1'b0, 1'b0);
        push_request(1'b0, 1'b0);
    endtask

    task automatic test_directed_corners();
        // gain above unity on a quarter-circle step: clamps at both signs
        load_settings(MODE_SINE, 32'h4000_0000, 20'd0, 16'hFFFF, 4'd0);
        push_request(1'b1, 1'b0);
        repeat (4)
        begin
            push_request(1'b0, 1'b0);
        end
        // longest fade, cut off by the next block start (block too short)
        load_settings(MODE_SINE, 32'h0123_4567, 20'd0, 16'd32768, 4'd15);
        push_request(1'b1, 1'b1);
        push_request(1'b0, 1'b0);
        push_request(1'b1, 1'b0);
        push_request(1'b0, 1'b1);
        // two-sample fade saturating at zero and at unity (block too long);
        // also the muted-to-muted and unmuted-to-unmuted pairs
        load_settings(MODE_SINE, 32'h0800_0000, 20'd0, 16'd32768, 4'd15);
        write_reg(REG_BLOCK_LOG2, 32'd1);
        push_request(1'b1, 1'b0);
        push_request(1'b1, 1'b1);
        push_request(1'b0, 1'b1);
        push_request(1'b0, 1'b1);
        push_request(1'b1, 1'b1);
        push_request(1'b1, 1'b0);
        push_request(1'b0, 1'b0);
        push_request(1'b0, 1'b0);
        // every wave mode; phases carry across mode changes
        load_settings(MODE_INTERMOD, 32'hFFFF_FFFF, 20'hFFFFF, 16'd32768, 4'd1);
        push_request(1'b0, 1'b0);
        push_request(1'b0, 1'b0);
        load_settings(MODE_LOW, 32'hFFFF_FFFF, HERTZ_STEP_RST, 16'd32768, 4'd1);
        push_request(1'b0, 1'b0);
        push_request(1'b0, 1'b0);
        // unused mode code plays the single sine
        load_settings(MODE_UNUSED, 32'hFFFF_FFFF, 20'd0, 16'd0, 4'd1);
        push_request(1'b0, 1'b0);
        settle();
        write_reg(REG_GAIN, 32'd32768);
        push_request(1'b0, 1'b0);
    endtask

    // Three idle profiles, several register settings each
    task automatic test_random_traffic();
        for (int seg = 0; seg < 3; seg++)
        begin
            case (seg)
                0:
                begin
                    send_idle_pct = 29;
                    recv_idle_pct = 73;
                end
                1:
                begin
                    send_idle_pct = 73;
                    recv_idle_pct = 29;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int ph = 0; ph < 6; ph++)
            begin
                random_settings();
                random_traffic(100);
            end
        end
    endtask

    // Long output hold-off while requests keep coming, so the block backs up and
    // stalls its input; then a full drain before more traffic.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_settings(MODE_INTERMOD, SINE_STEP_RST, HERTZ_STEP_RST, 16'd32768, 4'd3);
        push_request(1'b1, 1'b0);
        hold_left = 300;
        random_traffic(40);
        settle();
        recv_idle_pct = 50;
        hold_left = 150;
        random_traffic(30);
    endtask

    // Output side: stall during a hold-off, otherwise at the profile's rate
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Compare every accepted sample against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_samples.size() == 0)
            begin
                report_mismatch("sample with no request pending", sample, 0);
            end
            else
            begin
                if (sample !== pending_samples[0])
                begin
                    report_mismatch("sample", sample, pending_samples[0]);
                end
                void'(pending_samples.pop_front());
            end
            samples_checked++;
        end
    end

    initial
    begin
        for (int k = 0; k < ROM_SIZE; k++)
        begin
            sine_rom[k] = rom_entry(k);
        end
        for (int i = 0; i < TONES; i++)
        begin
            phase_acc[i] = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 29;
        recv_idle_pct = 73;
        test_after_reset();
        test_directed_corners();
        test_random_traffic();
        test_output_backpressure();

        // drain, then give the pipeline time to show any extra sample
        settle();
        repeat (32) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/tgm_pkg.sv
design/tgm_sine_rom.sv
design/tone_generator_with_mute_ramp.sv
test/tb_tone_generator_with_mute_ramp.sv
